/* sv/kgd_pkg.sv */
// ============================================================================
// kgd_pkg
// Shared types and constants for the key gesture detector: gesture state
// codes, event kinds, configuration register indexes and reset values.
// ============================================================================
`default_nettype none

package kgd_pkg;

    // Default geometry
    localparam int NUM_KEYS_DEF    = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    // Port widths fixed by the item format
    localparam int KEY_W  = 3;
    localparam int KIND_W = 2;
    localparam int SEQ_W  = 16;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 2;
    localparam int MASK_W = 8;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_PRESS_TICKS  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_LONG_TICKS   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_DOUBLE_TICKS = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_ANALOG_MASK  = 2'd3;

    // Configuration reset values
    localparam logic [CFG_W-1:0]  PRESS_TICKS_RST  = 16'd3;
    localparam logic [CFG_W-1:0]  LONG_TICKS_RST   = 16'd50;
    localparam logic [CFG_W-1:0]  DOUBLE_TICKS_RST = 16'd10;
    localparam logic [MASK_W-1:0] ANALOG_MASK_RST  = 8'd0;

    // Sequence counter reset value; first event carries this plus one
    localparam logic [SEQ_W-1:0] SEQ_RST = 16'd1;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_PROB    = 3'd1,
        ST_PRESSED = 3'd2,
        ST_WAIT    = 3'd3,
        ST_DOUBLE  = 3'd4,
        ST_LONG    = 3'd5
    } gesture_state_t;

    typedef enum logic [KIND_W-1:0] {
        EV_CLICK  = 2'd0,
        EV_DOUBLE = 2'd1,
        EV_LONG   = 2'd2
    } event_kind_t;

endpackage

`default_nettype wire

/* sv/key_gesture_detector_core.sv */
// ============================================================================
// key_gesture_detector_core
// Flow: the per-key memory is read into a register when an input is accepted,
//   then the update stage loads the output register when it retires with an event.
// Throughput: one item per cycle; input stalls only while the output register
//   is full and not taken and the item in the update stage emits an event.
// Reset: async active low; all keys idle (per-key valid bits), config
//   registers at defaults, sequence counter at one. No clearing pass needed.
// ============================================================================
`default_nettype none

module key_gesture_detector_core #(
    parameter int NUM_KEYS    = kgd_pkg::NUM_KEYS_DEF,
    parameter int COUNT_WIDTH = kgd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration write port
    input  wire logic                        cfg_we,
    input  wire logic [kgd_pkg::CIDX_W-1:0]  cfg_index,
    input  wire logic [kgd_pkg::CFG_W-1:0]   cfg_data,
    // scan tick items
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [kgd_pkg::KEY_W-1:0]   scan_key,
    input  wire logic                        pressed,
    // event items
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [kgd_pkg::KEY_W-1:0]        event_key,
    output logic [kgd_pkg::KIND_W-1:0]       event_kind,
    output logic [kgd_pkg::SEQ_W-1:0]        event_seq
);

    // Address width of the per-key memory
    localparam int KW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int AW    = KW + kgd_pkg::KEY_W;
    localparam int CW    = COUNT_WIDTH;
    // Compare width covers both counters and 16-bit thresholds
    localparam int CMP_W = (CW > kgd_pkg::CFG_W) ? CW : kgd_pkg::CFG_W;

    // One memory word per key
    typedef struct packed {
        kgd_pkg::gesture_state_t st;
        logic [CW-1:0]           hold;
        logic [CW-1:0]           rel;
        logic                    sec;
    } entry_t;

    localparam entry_t ENTRY_RST = '{
        st:   kgd_pkg::ST_IDLE,
        hold: '0,
        rel:  '0,
        sec:  1'b0
    };

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [kgd_pkg::CFG_W-1:0]  press_ticks_reg;
    logic [kgd_pkg::CFG_W-1:0]  long_ticks_reg;
    logic [kgd_pkg::CFG_W-1:0]  double_ticks_reg;
    logic [kgd_pkg::MASK_W-1:0] analog_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_ticks_reg  <= kgd_pkg::PRESS_TICKS_RST;
            long_ticks_reg   <= kgd_pkg::LONG_TICKS_RST;
            double_ticks_reg <= kgd_pkg::DOUBLE_TICKS_RST;
            analog_mask_reg  <= kgd_pkg::ANALOG_MASK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kgd_pkg::CFG_PRESS_TICKS:  press_ticks_reg  <= cfg_data;
                kgd_pkg::CFG_LONG_TICKS:   long_ticks_reg   <= cfg_data;
                kgd_pkg::CFG_DOUBLE_TICKS: double_ticks_reg <= cfg_data;
                kgd_pkg::CFG_ANALOG_MASK:  analog_mask_reg  <= cfg_data[kgd_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic                        s1_valid_reg;
    logic [kgd_pkg::KEY_W-1:0]   s1_key_reg;
    logic                        s1_p_reg;
    logic                        out_valid_reg;
    logic [kgd_pkg::SEQ_W-1:0]   seq_reg;

    logic                        ev;        // update stage emits an event
    kgd_pkg::event_kind_t        ev_kind;
    logic                        s1_go;     // update stage retires (writes back)
    logic                        in_fire;
    logic                        in_range;
    logic [AW-1:0]               in_wide;
    logic [AW-1:0]               s1_wide;
    logic [KW-1:0]               in_addr;
    logic [KW-1:0]               s1_addr;

    // Update stage may retire unless it needs a full, untaken output slot
    assign s1_go    = s1_valid_reg && (!ev || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;
    assign in_fire  = in_valid && in_ready;

    assign in_range = int'(scan_key) < NUM_KEYS;
    assign in_wide  = AW'(scan_key);
    assign s1_wide  = AW'(s1_key_reg);
    assign in_addr  = in_wide[KW-1:0];
    assign s1_addr  = s1_wide[KW-1:0];

    // ------------------------------------------------------------------
    // Per-key state memory, one read and one write port, registered read
    // ------------------------------------------------------------------
    entry_t                gesture_mem [NUM_KEYS];
    entry_t                rd_data_reg;
    entry_t                fwd_data_reg;
    entry_t                wr_entry;
    logic                  rd_vld_reg;
    logic                  fwd_hit_reg;
    logic [NUM_KEYS-1:0]   vld_reg;

    always_ff @(posedge clk)
    begin
        if (s1_go)
            gesture_mem[s1_addr] <= wr_entry;
        if (in_fire)
        begin
            rd_data_reg  <= gesture_mem[in_addr];
            fwd_data_reg <= wr_entry;
        end
    end

    // Valid bits stand in for clearing the memory at reset.
    // Same-key read during a write-back takes the value being written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (s1_go)
                vld_reg[s1_addr] <= 1'b1;
            if (in_fire)
            begin
                rd_vld_reg  <= vld_reg[in_addr];
                fwd_hit_reg <= s1_go && (s1_addr == in_addr);
            end
        end
    end

    // ------------------------------------------------------------------
    // Update stage: gesture state machine for the key in flight
    // ------------------------------------------------------------------
    entry_t          cur;
    logic [CW-1:0]   hold_inc;
    logic [CW-1:0]   rel_inc;
    logic            hold_ge_press;
    logic            hold_ge_long;
    logic            rel_ge_dbl;
    logic            analog;

    always_comb
    begin
        if (fwd_hit_reg)
            cur = fwd_data_reg;
        else if (rd_vld_reg)
            cur = rd_data_reg;
        else
            cur = ENTRY_RST;
    end

    // Saturating increments
    assign hold_inc = (s1_p_reg && (cur.hold != {CW{1'b1}})) ? cur.hold + CW'(1) : cur.hold;
    assign rel_inc  = (cur.rel != {CW{1'b1}}) ? cur.rel + CW'(1) : cur.rel;

    assign hold_ge_press = CMP_W'(hold_inc) >= CMP_W'(press_ticks_reg);
    assign hold_ge_long  = CMP_W'(hold_inc) >= CMP_W'(long_ticks_reg);
    assign rel_ge_dbl    = CMP_W'(rel_inc)  >= CMP_W'(double_ticks_reg);

    assign analog = analog_mask_reg[s1_key_reg];

    always_comb
    begin
        wr_entry      = cur;
        wr_entry.hold = hold_inc;
        ev            = 1'b0;
        ev_kind       = kgd_pkg::EV_CLICK;

        unique case (cur.st)
            kgd_pkg::ST_PROB:
            begin
                if (!cur.sec)
                begin
                    if (!s1_p_reg)
                    begin
                        wr_entry.st   = kgd_pkg::ST_IDLE;
                        wr_entry.hold = '0;
                    end
                    else if (hold_ge_press)
                        wr_entry.st = kgd_pkg::ST_PRESSED;
                end
                else
                begin
                    // second press: release gives a click, a held press a double
                    if (!s1_p_reg)
                    begin
                        wr_entry.st = kgd_pkg::ST_PRESSED;
                        ev          = 1'b1;
                        ev_kind     = kgd_pkg::EV_CLICK;
                    end
                    else if (hold_ge_press)
                    begin
                        wr_entry.st   = kgd_pkg::ST_DOUBLE;
                        wr_entry.hold = '0;
                        wr_entry.sec  = 1'b0;
                        ev            = 1'b1;
                        ev_kind       = kgd_pkg::EV_DOUBLE;
                    end
                end
            end
            kgd_pkg::ST_PRESSED:
            begin
                if (!s1_p_reg)
                begin
                    wr_entry.st   = kgd_pkg::ST_WAIT;
                    wr_entry.hold = '0;
                    wr_entry.rel  = '0;
                end
                else if (hold_ge_long)
                    wr_entry.st = kgd_pkg::ST_LONG;
            end
            kgd_pkg::ST_WAIT:
            begin
                if (!s1_p_reg)
                begin
                    if (rel_ge_dbl)
                    begin
                        // timeout without second press
                        wr_entry.st   = kgd_pkg::ST_IDLE;
                        wr_entry.hold = '0;
                        wr_entry.rel  = '0;
                        ev            = 1'b1;
                        ev_kind       = kgd_pkg::EV_CLICK;
                    end
                    else
                        wr_entry.rel = rel_inc;
                end
                else
                begin
                    wr_entry.st  = kgd_pkg::ST_PROB;
                    wr_entry.sec = 1'b1;
                end
            end
            kgd_pkg::ST_DOUBLE:
            begin
                if (!s1_p_reg)
                begin
                    wr_entry.st   = kgd_pkg::ST_IDLE;
                    wr_entry.hold = '0;
                end
            end
            kgd_pkg::ST_LONG:
            begin
                if (!s1_p_reg)
                begin
                    wr_entry.st   = kgd_pkg::ST_IDLE;
                    wr_entry.hold = '0;
                    ev            = !analog;
                    ev_kind       = kgd_pkg::EV_LONG;
                end
            end
            default:
            begin
                // idle and unused codes
                if (s1_p_reg)
                    wr_entry.st = kgd_pkg::ST_PROB;
                else
                begin
                    wr_entry.st   = kgd_pkg::ST_IDLE;
                    wr_entry.hold = '0;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stage and output registers
    // ------------------------------------------------------------------
    logic [kgd_pkg::KEY_W-1:0]  event_key_reg;
    logic [kgd_pkg::KIND_W-1:0] event_kind_reg;
    logic [kgd_pkg::SEQ_W-1:0]  event_seq_reg;
    logic [kgd_pkg::SEQ_W-1:0]  seq_next;

    assign seq_next = seq_reg + kgd_pkg::SEQ_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seq_reg       <= kgd_pkg::SEQ_RST;
        end
        else
        begin
            // out-of-range keys are dropped at the door
            if (in_fire)
                s1_valid_reg <= in_range;
            else if (s1_go)
                s1_valid_reg <= 1'b0;

            if (s1_go && ev)
            begin
                out_valid_reg <= 1'b1;
                seq_reg       <= seq_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_key_reg <= scan_key;
            s1_p_reg   <= pressed;
        end
        if (s1_go && ev)
        begin
            event_key_reg  <= s1_key_reg;
            event_kind_reg <= ev_kind;
            event_seq_reg  <= seq_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_key  = event_key_reg;
    assign event_kind = event_kind_reg;
    assign event_seq  = event_seq_reg;

endmodule

`default_nettype wire

/* sv/kgd_checker.sv */
// ============================================================================
// kgd_checker
// Port-level checks on the key gesture detector, bound to the top level.
// ============================================================================
`default_nettype none

module kgd_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [kgd_pkg::KEY_W-1:0]   event_key,
    input wire logic [kgd_pkg::KIND_W-1:0]  event_kind,
    input wire logic [kgd_pkg::SEQ_W-1:0]   event_seq
);

    // Stalled event holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_key)
            && $stable(event_kind) && $stable(event_seq))
        else $error("event changed while stalled");

    // Input only blocks when an event is waiting
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // Consecutive events carry consecutive numbers
    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) ##1 out_valid
            |-> event_seq == kgd_pkg::SEQ_W'($past(event_seq) + 1'b1))
        else $error("event sequence gap");

    // Kind code stays within the defined kinds
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_kind == kgd_pkg::EV_CLICK)
            || (event_kind == kgd_pkg::EV_DOUBLE) || (event_kind == kgd_pkg::EV_LONG))
        else $error("bad event kind");

endmodule

bind key_gesture_detector_core kgd_checker u_kgd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_key  (event_key),
    .event_kind (event_kind),
    .event_seq  (event_seq)
);

`default_nettype wire
